/* hdl/window_average_plot_mapper_macros.svh */
// ----------------------------------------------------------------------------
// Window average plot mapper assertion macros
// Shared concurrent assertion forms; expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef WINDOW_AVERAGE_PLOT_MAPPER_MACROS_SVH
`define WINDOW_AVERAGE_PLOT_MAPPER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define WAPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define WAPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wapm_pkg.sv */
// ----------------------------------------------------------------------------
// Window average plot mapper package
// Widths, screen constants, register indexes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wapm_pkg;

  localparam int MAX_WINDOW    = 64;
  localparam int RING_AW       = $clog2(MAX_WINDOW);
  localparam int SAMPLE_W      = 16;
  localparam int WIN_W         = 7;
  localparam int PTS_W         = 21;
  localparam int SUM_W         = SAMPLE_W + RING_AW;
  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 272;
  localparam int X_W           = 9;
  localparam int Y_W           = 9;
  localparam int SW_W          = 9;
  localparam int Y_PROD_W      = SAMPLE_W + Y_W;
  localparam int DIV_NUM_W     = 30;
  localparam int DIV_DEN_W     = 21;
  localparam int DIV_CNT_W     = $clog2(DIV_NUM_W + 1);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 21;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hdl/wapm_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wapm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/wapm_div.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divide, one quotient bit per cycle; quotient holds after busy drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wapm_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [wapm_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [wapm_pkg::DIV_DEN_W-1:0] den,
  output logic                                busy,
  output logic      [wapm_pkg::DIV_NUM_W-1:0] quo
);

  logic [wapm_pkg::DIV_DEN_W-1:0] rem;
  logic [wapm_pkg::DIV_DEN_W-1:0] den_q;
  logic [wapm_pkg::DIV_CNT_W-1:0] count;
  logic [wapm_pkg::DIV_DEN_W:0]   trial;
  logic [wapm_pkg::DIV_DEN_W:0]   diff;
  logic                           fits;

  always_comb begin
    trial = {rem, quo[wapm_pkg::DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= wapm_pkg::DIV_CNT_W'(wapm_pkg::DIV_NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      busy  <= (count != wapm_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[wapm_pkg::DIV_NUM_W-2:0], fits};
      rem <= fits ? diff[wapm_pkg::DIV_DEN_W-1:0] : trial[wapm_pkg::DIV_DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/window_average_plot_mapper.sv */
// ----------------------------------------------------------------------------
// Window average plot mapper
// Boxcar moving average over a sample ring, mapped to plot pixel coordinates.
// ----------------------------------------------------------------------------
// A sample that yields a plot point runs through the states UPDATE, DIVIDE and
// EMIT after acceptance. UPDATE updates the running sum from the oldest ring
// entry (read at the acceptance edge) and writes the ring, DIVIDE runs the two
// 30-bit restoring dividers (window average and x coordinate) side by side
// until both finish, and EMIT computes y and loads the output register once
// the output is free. The input is stalled meanwhile, so a new sample is not
// taken before the last point is loaded; a stalled output holds the block in
// its last step. A sample that only fills the window passes through UPDATE
// alone, and a sample after the run has finished is taken and dropped. The
// ring memory needs no clearing pass after reset. A write to the window size
// or point count register restarts the run with an empty window.
`timescale 1ns / 1ps
`default_nettype none

module window_average_plot_mapper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [wapm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wapm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [wapm_pkg::SAMPLE_W-1:0]   sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [wapm_pkg::SAMPLE_W-1:0]   average,
  output logic      [wapm_pkg::X_W-1:0]        x_coord,
  output logic      [wapm_pkg::Y_W-1:0]        y_coord,
  output logic                                 last_point
);

  wapm_pkg::state_t state;
  wapm_pkg::state_t state_next;

  logic [wapm_pkg::WIN_W-1:0]    window_size;
  logic [wapm_pkg::PTS_W-1:0]    num_points;
  logic [wapm_pkg::RING_AW-1:0]  ring_pointer;
  logic [wapm_pkg::SUM_W-1:0]    window_sum;
  logic [wapm_pkg::WIN_W-1:0]    fill_count;
  logic [wapm_pkg::PTS_W-1:0]    point_index;

  logic [wapm_pkg::RING_AW-1:0]  ring_pointer_next;
  logic [wapm_pkg::SUM_W-1:0]    window_sum_next;
  logic [wapm_pkg::WIN_W-1:0]    fill_count_next;

  logic [wapm_pkg::WIN_W-1:0]    win_eff;
  logic [wapm_pkg::PTS_W-1:0]    pts_eff;
  logic [wapm_pkg::RING_AW-1:0]  ptr_eff;
  logic [wapm_pkg::WIN_W-1:0]    ptr_inc;
  logic [wapm_pkg::SAMPLE_W-1:0] sample_q;
  logic [wapm_pkg::RING_AW-1:0]  ptr_q;
  logic                          last_q;
  logic [wapm_pkg::SAMPLE_W-1:0] ring_rdata;

  logic                          cfg_hit;
  logic                          in_take;
  logic                          run_done;
  logic                          window_full;
  logic                          emit;
  logic                          ring_we;
  logic                          div_start;
  logic                          out_load;

  logic                           avg_busy;
  logic                           x_busy;
  logic [wapm_pkg::DIV_NUM_W-1:0] avg_quo;
  logic [wapm_pkg::DIV_NUM_W-1:0] x_quo;
  logic [wapm_pkg::DIV_NUM_W-1:0] x_num;
  logic [wapm_pkg::Y_PROD_W-1:0]  y_prod;

  // effective configuration
  always_comb begin
    if (window_size == '0) begin
      win_eff = wapm_pkg::WIN_W'(1);
    end else if (window_size > wapm_pkg::WIN_W'(wapm_pkg::MAX_WINDOW)) begin
      win_eff = wapm_pkg::WIN_W'(wapm_pkg::MAX_WINDOW);
    end else begin
      win_eff = window_size;
    end
    pts_eff = (num_points == '0) ? wapm_pkg::PTS_W'(1) : num_points;
  end

  always_comb begin
    cfg_hit  = cfg_we && ((cfg_index == wapm_pkg::REG_WINDOW_SIZE) ||
                          (cfg_index == wapm_pkg::REG_NUM_POINTS));
    in_take  = in_valid && !in_stall;
    run_done = (point_index >= pts_eff);
    ptr_eff  = ({1'b0, ring_pointer} >= win_eff) ? '0 : ring_pointer;
  end

  // window update from the latched request and the oldest ring entry, plus x and y products
  always_comb begin
    window_full = (fill_count >= win_eff);
    if (window_full) begin
      window_sum_next = window_sum - wapm_pkg::SUM_W'(ring_rdata)
                      + wapm_pkg::SUM_W'(sample_q);
      fill_count_next = fill_count;
    end else begin
      window_sum_next = window_sum + wapm_pkg::SUM_W'(sample_q);
      fill_count_next = fill_count + 1'b1;
    end
    ptr_inc           = {1'b0, ptr_q} + 1'b1;
    ring_pointer_next = (ptr_inc >= win_eff) ? '0 : ptr_inc[wapm_pkg::RING_AW-1:0];
    emit              = (fill_count_next >= win_eff);
    x_num             = wapm_pkg::DIV_NUM_W'(point_index) *
                        wapm_pkg::SW_W'(wapm_pkg::SCREEN_WIDTH);
    y_prod            = avg_quo[wapm_pkg::SAMPLE_W-1:0] *
                        wapm_pkg::Y_W'(wapm_pkg::SCREEN_HEIGHT);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wapm_pkg::ST_IDLE: begin
        if (in_take && !run_done) begin
          state_next = wapm_pkg::ST_UPDATE;
        end
      end
      wapm_pkg::ST_UPDATE: begin
        state_next = emit ? wapm_pkg::ST_DIVIDE : wapm_pkg::ST_IDLE;
      end
      wapm_pkg::ST_DIVIDE: begin
        if (!avg_busy && !x_busy) begin
          state_next = wapm_pkg::ST_EMIT;
        end
      end
      wapm_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = wapm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wapm_pkg::ST_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall  = 1'b1;
    ring_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      wapm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      wapm_pkg::ST_UPDATE: begin
        ring_we   = 1'b1;
        div_start = emit;
      end
      wapm_pkg::ST_DIVIDE: begin
        in_stall = 1'b1;
      end
      wapm_pkg::ST_EMIT: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wapm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= wapm_pkg::WIN_W'(1);
      num_points  <= wapm_pkg::PTS_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == wapm_pkg::REG_WINDOW_SIZE) begin
        window_size <= cfg_data[wapm_pkg::WIN_W-1:0];
      end
      if (cfg_index == wapm_pkg::REG_NUM_POINTS) begin
        num_points <= cfg_data[wapm_pkg::PTS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      ring_pointer <= '0;
      window_sum   <= '0;
      fill_count   <= '0;
      point_index  <= '0;
    end else if (state == wapm_pkg::ST_UPDATE) begin
      ring_pointer <= ring_pointer_next;
      window_sum   <= window_sum_next;
      fill_count   <= fill_count_next;
      if (emit) begin
        point_index <= point_index + 1'b1;
      end
    end
  end

  // request payload and point flag
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_q <= sample;
      ptr_q    <= ptr_eff;
    end
    if (state == wapm_pkg::ST_UPDATE) begin
      last_q <= ((point_index + 1'b1) == pts_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average    <= avg_quo[wapm_pkg::SAMPLE_W-1:0];
      x_coord    <= x_quo[wapm_pkg::X_W-1:0];
      y_coord    <= y_prod[wapm_pkg::Y_PROD_W-1 -: wapm_pkg::Y_W];
      last_point <= last_q;
    end
  end

  wapm_ram #(
    .WIDTH (wapm_pkg::SAMPLE_W),
    .DEPTH (wapm_pkg::MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_q),
    .wdata (sample_q),
    .raddr (ptr_eff),
    .rdata (ring_rdata)
  );

  wapm_div u_avg_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (wapm_pkg::DIV_NUM_W'(window_sum_next)),
    .den   (wapm_pkg::DIV_DEN_W'(win_eff)),
    .busy  (avg_busy),
    .quo   (avg_quo)
  );

  wapm_div u_x_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (x_num),
    .den   (pts_eff),
    .busy  (x_busy),
    .quo   (x_quo)
  );

endmodule

`default_nettype wire

/* hdl/wapm_checker.sv */
// ----------------------------------------------------------------------------
// Window average plot mapper checker
// Port-level properties of the mapper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "window_average_plot_mapper_macros.svh"

module wapm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [wapm_pkg::SAMPLE_W-1:0]   average,
  input wire logic [wapm_pkg::X_W-1:0]        x_coord,
  input wire logic [wapm_pkg::Y_W-1:0]        y_coord,
  input wire logic                            last_point
);

  `WAPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  `WAPM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(average) && $stable(x_coord) && $stable(y_coord) && $stable(last_point), "stalled result changed")

  `WAPM_ASSERT_SAME(a_coord_range, out_valid, (x_coord < wapm_pkg::X_W'(wapm_pkg::SCREEN_WIDTH)) && (y_coord < wapm_pkg::Y_W'(wapm_pkg::SCREEN_HEIGHT)), "coordinate off screen")

  `WAPM_ASSERT_SAME(a_emit_busy, $rose(out_valid), $past(in_stall), "result appeared while idle")

endmodule

bind window_average_plot_mapper wapm_checker u_wapm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .average    (average),
  .x_coord    (x_coord),
  .y_coord    (y_coord),
  .last_point (last_point)
);

`default_nettype wire

/* tb/window_average_plot_mapper_test.sv */
// ----------------------------------------------------------------------------
// Window average plot mapper testbench
// Streams sample requests through the moving-average plot mapper with random
// gaps and output stalls, predicts every plot point from a local copy of the
// ring, sum and run counters, and compares each point field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_average_plot_mapper_test;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 900;

  localparam logic [wapm_pkg::CFG_IDX_W-1:0] SPARE_INDEX_LO = 2'd2;
  localparam logic [wapm_pkg::CFG_IDX_W-1:0] SPARE_INDEX_HI = 2'd3;

  typedef struct packed {
    logic [wapm_pkg::SAMPLE_W-1:0] average;
    logic [wapm_pkg::X_W-1:0]      x_coord;
    logic [wapm_pkg::Y_W-1:0]      y_coord;
    logic                          last_point;
  } plot_point_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [wapm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wapm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [wapm_pkg::SAMPLE_W-1:0]   sample = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [wapm_pkg::SAMPLE_W-1:0]   average;
  logic [wapm_pkg::X_W-1:0]        x_coord;
  logic [wapm_pkg::Y_W-1:0]        y_coord;
  logic                            last_point;

  logic [wapm_pkg::SAMPLE_W-1:0] pending_samples[$];
  plot_point_t                   expected_points[$];
  plot_point_t                   head_point;

  logic [wapm_pkg::SAMPLE_W-1:0] ring_copy [wapm_pkg::MAX_WINDOW];
  logic [wapm_pkg::WIN_W-1:0]    win_reg = 7'd1;
  logic [wapm_pkg::PTS_W-1:0]    pts_reg = 21'd1;
  int unsigned                   ring_ptr = 0;
  int unsigned                   win_sum = 0;
  int unsigned                   fill = 0;
  int unsigned                   point_idx = 0;

  int  cycle_count = 0;
  int  mismatches = 0;
  int  send_gap = 0;
  int  recv_wait = 0;
  bit  idle_on = 1'b1;

  window_average_plot_mapper uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .average    (average),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .last_point (last_point)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned effective_window();
    if (win_reg == 0) return 1;
    if (win_reg > wapm_pkg::MAX_WINDOW) return wapm_pkg::MAX_WINDOW;
    return win_reg;
  endfunction

  function automatic int unsigned effective_points();
    return (pts_reg == 0) ? 1 : pts_reg;
  endfunction

  function automatic logic [wapm_pkg::SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic predict_point(input logic [wapm_pkg::SAMPLE_W-1:0] s);
    int unsigned     w;
    int unsigned     n;
    int unsigned     avg;
    longint unsigned xv;
    longint unsigned yv;
    plot_point_t     p;
    w = effective_window();
    n = effective_points();
    if (point_idx < n) begin
      if (ring_ptr >= w) ring_ptr = 0;
      if (fill >= w) win_sum -= ring_copy[wapm_pkg::RING_AW'(ring_ptr)];
      else fill++;
      ring_copy[wapm_pkg::RING_AW'(ring_ptr)] = s;
      win_sum += s;
      ring_ptr = (ring_ptr + 1 >= w) ? 0 : ring_ptr + 1;
      if (fill >= w) begin
        avg = win_sum / w;
        xv = (64'(point_idx) * 64'(wapm_pkg::SCREEN_WIDTH)) / 64'(n);
        yv = (64'(avg) * 64'(wapm_pkg::SCREEN_HEIGHT)) >> 16;
        p.average    = avg[wapm_pkg::SAMPLE_W-1:0];
        p.x_coord    = xv[wapm_pkg::X_W-1:0];
        p.y_coord    = yv[wapm_pkg::Y_W-1:0];
        p.last_point = (point_idx + 1 == n);
        expected_points.push_back(p);
        point_idx++;
      end
    end
  endtask

  task automatic write_reg(input logic [wapm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wapm_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == wapm_pkg::REG_WINDOW_SIZE || idx == wapm_pkg::REG_NUM_POINTS) begin
      if (idx == wapm_pkg::REG_WINDOW_SIZE) win_reg = value[wapm_pkg::WIN_W-1:0];
      else pts_reg = value[wapm_pkg::PTS_W-1:0];
      ring_ptr  = 0;
      win_sum   = 0;
      fill      = 0;
      point_idx = 0;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_points.size() != 0)
      @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_point(sample);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample   <= pending_samples.pop_front();
          in_valid <= 1'b1;
          send_gap = idle_on ? $urandom_range(0, 15) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("point with nothing expected, average %0d", average));
        end else begin
          head_point = expected_points.pop_front();
          if (average !== head_point.average)
            report_mismatch($sformatf("average %0d, want %0d", average, head_point.average));
          if (x_coord !== head_point.x_coord)
            report_mismatch($sformatf("x_coord %0d, want %0d", x_coord, head_point.x_coord));
          if (y_coord !== head_point.y_coord)
            report_mismatch($sformatf("y_coord %0d, want %0d", y_coord, head_point.y_coord));
          if (last_point !== head_point.last_point)
            report_mismatch($sformatf("last_point %0b, want %0b", last_point,
                                      head_point.last_point));
        end
        recv_wait = idle_on ? $urandom_range(0, 15) : 0;
      end else if (out_valid && recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0);
    end
  end

  initial begin
    int unsigned     i;
    int unsigned     w_eff;
    int unsigned     n_eff;
    int unsigned     len;
    int unsigned     pause_at;
    int unsigned     pick;
    int unsigned     counted;
    int unsigned     full;
    logic [wapm_pkg::CFG_DATA_W-1:0] value;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: one point, then the run is over
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h1234);
    pending_samples.push_back(16'h0000);
    wait_idle();

    // window size zero acts as one; hold off mid-run until drained
    write_reg(wapm_pkg::REG_WINDOW_SIZE, 21'd0);
    write_reg(wapm_pkg::REG_NUM_POINTS, 21'd3);
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'hFFFF);
    wait_drained();
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h5555);
    wait_idle();

    // point count zero acts as one
    write_reg(wapm_pkg::REG_NUM_POINTS, 21'd0);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h0001);
    wait_idle();

    // partial fill, then a same-value write restarts the window
    write_reg(wapm_pkg::REG_WINDOW_SIZE, 21'd3);
    write_reg(wapm_pkg::REG_NUM_POINTS, 21'd2);
    pending_samples.push_back(16'h0001);
    pending_samples.push_back(16'h0002);
    wait_idle();
    write_reg(wapm_pkg::REG_NUM_POINTS, 21'd2);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'hFFFF);
    wait_idle();

    // writes beyond the register list leave the partial window alone
    write_reg(SPARE_INDEX_LO, 21'h1FFFFF);
    write_reg(SPARE_INDEX_HI, 21'h0AAAAA);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h0001);
    pending_samples.push_back(16'h0007);
    wait_idle();

    // oversized window saturates, full-scale sum
    write_reg(wapm_pkg::REG_WINDOW_SIZE, 21'd127);
    write_reg(wapm_pkg::REG_NUM_POINTS, 21'h100000);
    for (i = 0; i < 84; i++) pending_samples.push_back(16'hFFFF);
    wait_idle();

    // sweep x across the whole screen width
    write_reg(wapm_pkg::REG_WINDOW_SIZE, 21'd1);
    write_reg(wapm_pkg::REG_NUM_POINTS, 21'd480);
    for (i = 0; i < 482; i++) pending_samples.push_back(draw_sample());
    wait_idle();

    write_reg(wapm_pkg::REG_WINDOW_SIZE, 21'd64);
    write_reg(wapm_pkg::REG_NUM_POINTS, 21'h1FFFFF);
    for (i = 0; i < 103; i++) pending_samples.push_back(draw_sample());
    wait_idle();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 2);
      if (pick != 1) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            case ($urandom_range(0, 4))
              0: value = 21'd0;
              1: value = 21'd1;
              2: value = 21'd64;
              3: value = 21'd127;
              default: value = 21'($urandom_range(65, 126));
            endcase
          end
          8, 9: value = 21'($urandom_range(13, 64));
          default: value = 21'($urandom_range(1, 12));
        endcase
        write_reg(wapm_pkg::REG_WINDOW_SIZE, value);
      end
      if (pick != 0) begin
        case ($urandom_range(0, 9))
          0: value = 21'd0;
          1: begin
            case ($urandom_range(0, 2))
              0: value = 21'h100000;
              1: value = 21'h1FFFFF;
              default: value = 21'($urandom);
            endcase
          end
          default: value = 21'($urandom_range(1, 40));
        endcase
        write_reg(wapm_pkg::REG_NUM_POINTS, value);
      end
      idle_on <= ($urandom_range(0, 3) != 0);

      w_eff = effective_window();
      n_eff = effective_points();
      full  = w_eff - 1 + n_eff;
      if (full <= w_eff - 1 + 60) len = full + $urandom_range(0, 3);
      else len = w_eff - 1 + $urandom_range(10, 60);
      // cut the run short now and then
      if ($urandom_range(0, 7) == 0) len = $urandom_range(0, len);
      pause_at = ($urandom_range(0, 7) == 0) ? len / 2 : len;

      for (i = 0; i < len; i++) begin
        if (i == pause_at && i != 0) wait_drained();
        pending_samples.push_back(draw_sample());
      end
      counted += (len < full) ? len : full;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
